// File: rtl/psf_pkg.sv
// Shared constants, payload types, codes and control structs of the packet slot queue.
package psf_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_BYTES = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int POS_W      = $clog2(SLOT_BYTES);
  localparam int LEN_W      = POS_W + 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int BYTE_DEPTH = SLOTS * SLOT_BYTES;
  localparam int QUEUE_W    = SLOT_W + LEN_W;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_DATA  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_HEAD,
    STATE_BYTE
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data_out;
    logic             last_out;
    logic [LEN_W-1:0] length;
    logic             stored;
    logic [CNT_W-1:0] free_slots;
    logic [CNT_W-1:0] packets_waiting;
  } rsp_t;

  typedef struct packed {
    logic              claim;
    logic              free_en;
    logic [SLOT_W-1:0] free_slot;
  } alloc_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] lowest;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  free_count_next;
  } alloc_stat_t;

endpackage

// File: rtl/psf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module psf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/psf_alloc.sv
// Slot occupancy bitmap, lowest-free-slot encoder and free slot counter.
module psf_alloc (
  input  logic                  clk,
  input  logic                  rst,
  input  psf_pkg::alloc_ctrl_t  ctrl,
  output psf_pkg::alloc_stat_t  stat
);
  import psf_pkg::*;

  logic [SLOTS-1:0]  slot_used;
  logic [SLOTS-1:0]  slot_used_next;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  free_count_next;
  logic              found;
  logic [SLOT_W-1:0] lowest;

  // scan downwards so the lowest free slot wins
  always_comb begin
    found  = 1'b0;
    lowest = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!slot_used[s]) begin
        found  = 1'b1;
        lowest = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    slot_used_next  = slot_used;
    free_count_next = free_count;
    if (ctrl.claim) begin
      slot_used_next[lowest] = 1'b1;
      free_count_next        = free_count - CNT_W'(1);
    end
    if (ctrl.free_en) begin
      slot_used_next[ctrl.free_slot] = 1'b0;
      free_count_next                = free_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= '0;
      free_count <= CNT_W'(SLOTS);
    end else begin
      slot_used  <= slot_used_next;
      free_count <= free_count_next;
    end
  end

  assign stat.found           = found;
  assign stat.lowest          = lowest;
  assign stat.free_count      = free_count;
  assign stat.free_count_next = free_count_next;

`ifndef NO_ASSERTIONS
  a_claim_needs_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.claim |-> found)
    else $error("slot claimed with no free slot");

  a_free_of_used: assert property (@(posedge clk) disable iff (rst)
    ctrl.free_en |-> slot_used[ctrl.free_slot])
    else $error("slot freed that was not in use");

  a_count_tracks_bitmap: assert property (@(posedge clk) disable iff (rst)
    free_count == CNT_W'(SLOTS - $countones(slot_used)))
    else $error("free slot count disagrees with the bitmap");
`endif

endmodule

// File: rtl/packet_slot_fifo.sv
// Top level of the packet slot queue: control sequencer, queue and byte memories, result register.
//
//   channel | valid     | stall     | payload | item
//   --------+-----------+-----------+---------+-------------------------------------
//   request | req_valid | req_stall | req     | write one packet byte or read a byte
//   result  | rsp_valid | rsp_stall | rsp     | status, byte, length, counts
//
// A write item, or a read of an empty queue, is loaded directly into the result
// register. A read of a queued byte goes in order: the queue memory returns the
// head entry (slot and length), the byte memory returns the byte, and the byte
// is delivered. Reset clears the slot bitmap, pointers and counters; both
// memories stay undefined until written, so there is no clearing pass.
// A stalled result holds in the result register; a new item is taken once the
// sequencer is idle and the register is empty or being emptied in the same cycle.
module packet_slot_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  psf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output psf_pkg::rsp_t rsp
);
  import psf_pkg::*;

  // sequencer
  state_t state;
  state_t state_next;

  // write-side packet state
  logic              write_active;
  logic              write_drop;
  logic [SLOT_W-1:0] write_slot;
  logic [LEN_W-1:0]  write_len;

  // queue order and read position
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr;
  logic [CNT_W-1:0]  queued_count;
  logic [CNT_W-1:0]  queued_count_next;
  logic [POS_W-1:0]  read_pos;

  // handshake and control
  logic accept;
  logic out_free;
  logic is_write;
  logic is_read;
  logic read_empty;
  logic deliver;
  logic load;
  logic b_rd_en;

  // write datapath
  logic              starting;
  logic              drop_now;
  logic [SLOT_W-1:0] slot_now;
  logic [LEN_W-1:0]  len_now;
  logic [LEN_W-1:0]  len_new;
  logic              room;
  logic              byte_kept;
  logic              queue_now;

  // memory ports
  logic                          b_wr_en;
  logic [$clog2(BYTE_DEPTH)-1:0] b_wr_addr;
  logic [$clog2(BYTE_DEPTH)-1:0] b_rd_addr;
  logic [7:0]                    b_rd_data;
  logic                          q_wr_en;
  logic                          q_rd_en;
  logic [QUEUE_W-1:0]            q_wr_data;
  logic [QUEUE_W-1:0]            q_rd_data;

  // read datapath
  logic [SLOT_W-1:0] head_slot;
  logic [LEN_W-1:0]  head_len;
  logic              last_byte;

  alloc_ctrl_t alloc_ctrl;
  alloc_stat_t alloc_stat;
  rsp_t        res;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
    ring_next = (p == SLOT_W'(SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  // handshake: one item in flight, result register must have room
  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != STATE_IDLE) || !out_free;
  assign accept     = req_valid && !req_stall;
  assign is_write   = accept && (req.action == ACT_WRITE);
  assign is_read    = accept && (req.action == ACT_READ);
  assign read_empty = (queued_count == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      STATE_IDLE: begin
        if (is_read && !read_empty) begin
          state_next = STATE_HEAD;
        end
      end
      STATE_HEAD: begin
        state_next = STATE_BYTE;
      end
      STATE_BYTE: begin
        if (out_free) begin
          state_next = STATE_IDLE;
        end
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_rd_en = 1'b0;
    b_rd_en = 1'b0;
    deliver = 1'b0;
    unique case (state)
      STATE_IDLE: q_rd_en = is_read && !read_empty;
      STATE_HEAD: b_rd_en = 1'b1;
      STATE_BYTE: deliver = out_free;
      default: begin
        q_rd_en = 1'b0;
      end
    endcase
  end

  // write path: claim a slot on the first byte, store while there is room
  always_comb begin
    starting  = !write_active;
    drop_now  = starting ? !alloc_stat.found : write_drop;
    slot_now  = (starting && alloc_stat.found) ? alloc_stat.lowest : write_slot;
    len_now   = starting ? '0 : write_len;
    room      = len_now < LEN_W'(SLOT_BYTES);
    byte_kept = !drop_now && room;
    len_new   = byte_kept ? len_now + LEN_W'(1) : len_now;
    queue_now = req.last && !drop_now && (queued_count < CNT_W'(SLOTS));
  end

  assign b_wr_en   = is_write && byte_kept;
  assign b_wr_addr = {slot_now, len_now[POS_W-1:0]};
  assign q_wr_en   = is_write && queue_now;
  assign q_wr_data = {slot_now, len_new};

  // read path: the queue entry carries slot and length together
  assign head_slot = q_rd_data[QUEUE_W-1:LEN_W];
  assign head_len  = q_rd_data[LEN_W-1:0];
  assign b_rd_addr = {head_slot, read_pos};
  assign last_byte = ({1'b0, read_pos} + LEN_W'(1)) >= head_len;

  assign alloc_ctrl.claim     = is_write && starting && alloc_stat.found;
  assign alloc_ctrl.free_en   = deliver && last_byte;
  assign alloc_ctrl.free_slot = head_slot;

  always_comb begin
    queued_count_next = queued_count;
    if (q_wr_en) begin
      queued_count_next = queued_count + CNT_W'(1);
    end else if (deliver && last_byte) begin
      queued_count_next = queued_count - CNT_W'(1);
    end
  end

  // result item
  always_comb begin
    res                 = '0;
    res.status          = STAT_OK;
    res.free_slots      = alloc_stat.free_count_next;
    res.packets_waiting = queued_count_next;
    if (is_write) begin
      if (drop_now) begin
        res.status = STAT_FULL;
      end else if (!room) begin
        res.status = STAT_OVERFLOW;
      end
      res.stored = queue_now;
    end else if (is_read && read_empty) begin
      res.status = STAT_NO_DATA;
    end else if (deliver) begin
      res.data_out = b_rd_data;
      res.last_out = last_byte;
      res.length   = head_len;
    end
  end

  assign load = is_write || (is_read && read_empty) || deliver;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= STATE_IDLE;
      write_active <= 1'b0;
      write_drop   <= 1'b0;
      write_slot   <= '0;
      write_len    <= '0;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      queued_count <= '0;
      read_pos     <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      queued_count <= queued_count_next;
      // close the packet on its last byte, otherwise carry on
      if (is_write) begin
        if (req.last) begin
          write_active <= 1'b0;
          write_drop   <= 1'b0;
          write_len    <= '0;
        end else begin
          write_active <= 1'b1;
          write_drop   <= drop_now;
          write_slot   <= slot_now;
          write_len    <= len_new;
        end
      end
      if (q_wr_en) begin
        tail_ptr <= ring_next(tail_ptr);
      end
      // advance through the head packet, drop it after its last byte
      if (deliver) begin
        if (last_byte) begin
          read_pos <= '0;
          head_ptr <= ring_next(head_ptr);
        end else begin
          read_pos <= read_pos + POS_W'(1);
        end
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

  psf_alloc u_alloc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (alloc_ctrl),
    .stat (alloc_stat)
  );

  // packet bytes, addressed by slot and position
  psf_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (req.data),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  // arrival-order ring of queued packets: slot number and length
  psf_ram #(
    .WIDTH (QUEUE_W),
    .DEPTH (SLOTS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (tail_ptr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (head_ptr),
    .rd_data (q_rd_data)
  );

`ifndef NO_ASSERTIONS
  a_slot_budget: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, queued_count} + {1'b0, alloc_stat.free_count}) <= (CNT_W + 1)'(SLOTS))
    else $error("queued plus free slots exceed the slot count");

  a_drop_only_active: assert property (@(posedge clk) disable iff (rst)
    !write_active |-> !write_drop)
    else $error("drop flag set outside a packet");

  a_head_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == STATE_HEAD) |-> (queued_count != '0))
    else $error("head entry fetched from an empty queue");

  a_stored_counted: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.stored) |-> (rsp.packets_waiting != '0))
    else $error("stored pulse with no packet waiting");
`endif

endmodule
